// ===== rtl/core/psched_pkg.sv =====
package psched_pkg;

  // Fixed field widths.
  localparam int COUNT_W = 7;

  // Defaults for the top-level parameters.
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_TASK_ID_BITS = 8;

  // Value of the running limit after reset.
  localparam logic [COUNT_W-1:0] MAX_RUNNING_RESET = 7'd4;

  // Number of priority levels, one queue each.
  localparam int NUM_PRIO = 3;

  // Priority codes.
  localparam logic [1:0] PRIO_HIGH   = 2'd0;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;
  localparam logic [1:0] PRIO_LOW    = 2'd2;

  // Action codes.
  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } sched_state_t;

  // Result of one word, without the task id.
  typedef struct packed {
    logic               valid;
    logic               start_valid;
    logic               queued;
    logic               rejected;
    logic [COUNT_W-1:0] running_count;
  } res_flags_t;

endpackage

// ===== rtl/core/psched_mem.sv =====
module psched_mem
  import psched_pkg::*;
#(
  parameter int ADDR_W = 6,
  parameter int DATA_W = DEF_TASK_ID_BITS
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  // Three queues share one array; the upper address bits pick the queue.
  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/psched_ctrl.sv =====
module psched_ctrl
  import psched_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = DEF_TASK_ID_BITS,
  parameter int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  parameter int ADDR_W       = PTR_W + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic                    slot_free,
  input  logic                    action,
  input  logic [1:0]              priority_req,
  input  logic [TASK_ID_BITS-1:0] task_id,
  input  logic                    cfg_fire,
  input  logic [COUNT_W-1:0]      cfg_data,
  output logic                    busy,
  output logic                    mem_wr_en,
  output logic [ADDR_W-1:0]       mem_wr_addr,
  output logic [TASK_ID_BITS-1:0] mem_wr_data,
  output logic                    mem_rd_en,
  output logic [ADDR_W-1:0]       mem_rd_addr,
  input  logic [TASK_ID_BITS-1:0] mem_rd_data,
  output res_flags_t              res,
  output logic [TASK_ID_BITS-1:0] res_task
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  sched_state_t       state, state_next;
  logic [COUNT_W-1:0] max_running;
  logic [COUNT_W-1:0] running, running_next;
  logic [PTR_W-1:0]   heads [NUM_PRIO];
  logic [PTR_W-1:0]   heads_next [NUM_PRIO];
  logic [FILL_W-1:0]  fills [NUM_PRIO];
  logic [FILL_W-1:0]  fills_next [NUM_PRIO];

  logic [1:0]         prio;
  logic [1:0]         pop_prio;
  logic               any_queued;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W:0]     head_inc;
  logic [COUNT_W-1:0] run_dec;

  // Priority code three is served as low.
  assign prio = (priority_req == 2'd3) ? PRIO_LOW : priority_req;

  // Highest-priority queue that holds anything.
  always_comb begin
    any_queued = 1'b1;
    priority if (fills[PRIO_HIGH] != '0) begin
      pop_prio = PRIO_HIGH;
    end else if (fills[PRIO_NORMAL] != '0) begin
      pop_prio = PRIO_NORMAL;
    end else begin
      pop_prio   = PRIO_LOW;
      any_queued = (fills[PRIO_LOW] != '0);
    end
  end

  // Tail slot of the submit queue, wrapped into the queue depth.
  always_comb begin
    tail_sum = SUM_W'(heads[prio]) + SUM_W'(fills[prio]);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
  end

  // Next head of the queue being popped.
  always_comb begin
    head_inc = (PTR_W + 1)'(heads[pop_prio]) + 1'b1;
    if (head_inc == (PTR_W + 1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  assign run_dec = running - 1'b1;
  assign busy    = (state != ST_IDLE);

  // Next state, counter updates, memory requests and the result word.
  always_comb begin
    state_next   = state;
    running_next = running;
    heads_next   = heads;
    fills_next   = fills;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = {prio, tail};
    mem_wr_data  = task_id;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = {pop_prio, heads[pop_prio]};
    res          = '0;
    res_task     = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (action == ACT_SUBMIT) begin
            res.valid = 1'b1;
            if (running < max_running) begin
              running_next    = running + 1'b1;
              res.start_valid = 1'b1;
              res_task        = task_id;
            end else if (fills[prio] == FILL_W'(QUEUE_DEPTH)) begin
              res.rejected = 1'b1;
            end else begin
              mem_wr_en        = 1'b1;
              fills_next[prio] = fills[prio] + 1'b1;
              res.queued       = 1'b1;
            end
            res.running_count = running_next;
          end else begin
            if (running == '0) begin
              res.valid         = 1'b1;
              res.rejected      = 1'b1;
              res.running_count = running;
            end else if ((run_dec < max_running) && any_queued) begin
              // The started task takes the finished one's place: count holds.
              mem_rd_en            = 1'b1;
              heads_next[pop_prio] = PTR_W'(head_inc);
              fills_next[pop_prio] = fills[pop_prio] - 1'b1;
              state_next           = ST_POP;
            end else begin
              running_next      = run_dec;
              res.valid         = 1'b1;
              res.running_count = run_dec;
            end
          end
        end
      end
      ST_POP: begin
        // The output slot was free when the finish word was taken.
        res.valid         = slot_free;
        res.start_valid   = 1'b1;
        res.running_count = running;
        res_task          = mem_rd_data;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters, queue pointers and the running limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= '0;
      max_running <= MAX_RUNNING_RESET;
      for (int i = 0; i < NUM_PRIO; i++) begin
        heads[i] <= '0;
        fills[i] <= '0;
      end
    end else begin
      running <= running_next;
      heads   <= heads_next;
      fills   <= fills_next;
      if (cfg_fire) begin
        max_running <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/core/priority_admission_scheduler.sv =====
// A submit, or a finish that starts nothing from a queue, has its result registered straight
// into the output register; a finish that starts a queued task first reads the queue memory.
// Throughput: one word per cycle while the output register is free, but a finish that pops a
// queue holds the input off while the queue memory read completes.
// Reset: running count, queue pointers and fill counts clear, the limit returns to 4;
// queue memory contents are not cleared and need no clearing pass.
module priority_admission_scheduler
  import psched_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    action,
  input  logic [1:0]              priority_req,
  input  logic [TASK_ID_BITS-1:0] task_id,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    start_valid,
  output logic [TASK_ID_BITS-1:0] start_task,
  output logic                    queued,
  output logic                    rejected,
  output logic [COUNT_W-1:0]      running_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [COUNT_W-1:0]      cfg_data
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ADDR_W = PTR_W + 2;

  logic                    slot_free;
  logic                    busy;
  logic                    in_fire;
  logic                    mem_wr_en;
  logic [ADDR_W-1:0]       mem_wr_addr;
  logic [TASK_ID_BITS-1:0] mem_wr_data;
  logic                    mem_rd_en;
  logic [ADDR_W-1:0]       mem_rd_addr;
  logic [TASK_ID_BITS-1:0] mem_rd_data;
  res_flags_t              res;
  logic [TASK_ID_BITS-1:0] res_task;

  // The output register is free when empty or being taken this cycle.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = !busy && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  psched_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .PTR_W        (PTR_W),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .slot_free    (slot_free),
    .action       (action),
    .priority_req (priority_req),
    .task_id      (task_id),
    .cfg_fire     (cfg_valid),
    .cfg_data     (cfg_data),
    .busy         (busy),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .res          (res),
    .res_task     (res_task)
  );

  psched_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (TASK_ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      start_valid   <= res.start_valid;
      start_task    <= res_task;
      queued        <= res.queued;
      rejected      <= res.rejected;
      running_count <= res.running_count;
    end
  end

endmodule

// ===== bench/priority_admission_scheduler_test.sv =====
`timescale 1ns / 100ps

module priority_admission_scheduler_test;
  import psched_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  localparam int ID_W = DEF_TASK_ID_BITS;
  localparam logic [1:0] PRIO_UNUSED = 2'd3;
  localparam int PLAN_ROWS = 28;
  localparam int RANDOM_WORDS = 830;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int END_WAIT_LIMIT = 4000;
  localparam int TIMEOUT_NS = 4000000;

  // One result word as the block reports it.
  typedef struct packed {
    logic               start_valid;
    logic [ID_W-1:0]    start_task;
    logic               queued;
    logic               rejected;
    logic [COUNT_W-1:0] running_count;
  } admit_result_t;

  localparam admit_result_t NO_RESULT = '0;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  // One row of the opening plan: a word to send or a limit to write.
  typedef struct packed {
    row_kind_t          kind;
    logic               act;
    logic [1:0]         prio;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] limit;
    logic               typed;
    admit_result_t      want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_SUBMIT;
  logic [1:0] priority_req = PRIO_HIGH;
  logic [ID_W-1:0] task_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic start_valid;
  logic [ID_W-1:0] start_task;
  logic queued;
  logic rejected;
  logic [COUNT_W-1:0] running_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Shadow copy of the scheduler state.
  logic [ID_W-1:0] pend_ids [NUM_PRIO][QDEPTH];
  int pend_head [NUM_PRIO] = '{0, 0, 0};
  int pend_fill [NUM_PRIO] = '{0, 0, 0};
  logic [COUNT_W-1:0] running_now = '0;
  logic [COUNT_W-1:0] limit_now = MAX_RUNNING_RESET;

  admit_result_t pending_results [$];

  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int starts_seen = 0;
  int queued_seen = 0;
  int rejects_seen = 0;
  int limits_written = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  plan_row_t opening_plan [PLAN_ROWS] = '{
    // Fill the four slots of the reset limit, unused priority goes low.
    '{ROW_WORD, ACT_SUBMIT, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 7'd1}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_NORMAL, 8'hFF, 7'd0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 7'd2}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_UNUSED, 8'h5A, 7'd0, 1'b1, '{1'b1, 8'h5A, 1'b0, 1'b0, 7'd3}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_LOW,    8'hA5, 7'd0, 1'b1, '{1'b1, 8'hA5, 1'b0, 1'b0, 7'd4}},
    // At the limit every submit is queued.
    '{ROW_WORD, ACT_SUBMIT, PRIO_LOW,    8'h3C, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_UNUSED, 8'hC3, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_NORMAL, 8'h81, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_SUBMIT, PRIO_HIGH,   8'h7E, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd4}},
    // Finishes pop high, then normal, then low in arrival order.
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b1, 8'h7E, 1'b0, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b1, 8'h81, 1'b0, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_FINISH, PRIO_LOW,    8'hFF, 7'd0, 1'b1, '{1'b1, 8'h3C, 1'b0, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_FINISH, PRIO_UNUSED, 8'hFF, 7'd0, 1'b1, '{1'b1, 8'hC3, 1'b0, 1'b0, 7'd4}},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 7'd3}},
    '{ROW_WORD, ACT_FINISH, PRIO_NORMAL, 8'h11, 7'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_FINISH, PRIO_LOW,    8'h22, 7'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h33, 7'd0, 1'b0, NO_RESULT},
    // A finish with nothing running is rejected.
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 7'd0}},
    // A zero limit queues everything.
    '{ROW_CFG,  ACT_SUBMIT, PRIO_HIGH,   8'h00, 7'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_SUBMIT, PRIO_HIGH,   8'h12, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd0}},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 7'd0}},
    // Raising the limit starts nothing; a new submit bypasses the queue.
    '{ROW_CFG,  ACT_SUBMIT, PRIO_HIGH,   8'h00, 7'd127, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_SUBMIT, PRIO_NORMAL, 8'h34, 7'd0, 1'b1, '{1'b1, 8'h34, 1'b0, 1'b0, 7'd1}},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b1, '{1'b1, 8'h12, 1'b0, 1'b0, 7'd1}},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b0, NO_RESULT},
    // Smallest nonzero limit.
    '{ROW_CFG,  ACT_SUBMIT, PRIO_HIGH,   8'h00, 7'd1, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_SUBMIT, PRIO_LOW,    8'hFF, 7'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_SUBMIT, PRIO_HIGH,   8'h00, 7'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, ACT_FINISH, PRIO_HIGH,   8'h00, 7'd0, 1'b0, NO_RESULT}
  };

  priority_admission_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .priority_req (priority_req),
    .task_id      (task_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_valid  (start_valid),
    .start_task   (start_task),
    .queued       (queued),
    .rejected     (rejected),
    .running_count(running_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Works out the result of one admitted word and advances the shadow state.
  function automatic admit_result_t predict_admission(input logic act, input logic [1:0] prio,
                                                      input logic [ID_W-1:0] id);
    admit_result_t r;
    int p;
    int q;
    int slot;
    r = '0;
    p = (prio > PRIO_LOW) ? int'(PRIO_LOW) : int'(prio);
    if (act == ACT_SUBMIT) begin
      if (running_now < limit_now) begin
        r.start_valid = 1'b1;
        r.start_task = id;
      end else if (pend_fill[p] >= QDEPTH) begin
        r.rejected = 1'b1;
      end else begin
        slot = (pend_head[p] + pend_fill[p]) % QDEPTH;
        pend_ids[p][slot] = id;
        pend_fill[p]++;
        r.queued = 1'b1;
      end
    end else if (running_now == '0) begin
      r.rejected = 1'b1;
    end else begin
      running_now = running_now - 1'b1;
      if (running_now < limit_now) begin
        for (q = 0; q < NUM_PRIO; q++) begin
          if (!r.start_valid && pend_fill[q] != 0) begin
            r.start_valid = 1'b1;
            r.start_task = pend_ids[q][pend_head[q]];
            pend_head[q] = (pend_head[q] + 1) % QDEPTH;
            pend_fill[q]--;
          end
        end
      end
    end
    if (r.start_valid) running_now = running_now + 1'b1;
    r.running_count = running_now;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while the no-idle stretch runs.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] got,
                             input logic [ID_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h", results_seen, name,
                                got, want));
  endtask

  // Offers one word and records its expected result once it is taken.
  task automatic send_word(input logic act, input logic [1:0] prio, input logic [ID_W-1:0] id,
                           input logic typed, input admit_result_t want);
    int gap;
    admit_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    priority_req <= prio;
    task_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_admission(act, prio, id);
    if (typed) r = want;
    pending_results.push_back(r);
    words_sent++;
    starts_seen += r.start_valid;
    queued_seen += r.queued;
    rejects_seen += r.rejected;
  endtask

  // Stops offering words and waits until every result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_now = value;
    limits_written++;
    cfg_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    admit_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("start_valid", start_valid, want.start_valid);
        check_field("start_task", start_task, want.start_task);
        check_field("queued", queued, want.queued);
        check_field("rejected", rejected, want.rejected);
        check_field("running_count", running_count, want.running_count);
      end
      results_seen++;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Main sequence: reset, opening plan, random phases, drain.
  initial begin
    int phase;
    int phase_words;
    int random_sent;
    int mode;
    int len;
    int waited;
    int fixed_limits [6];
    logic [1:0] main_prio;
    logic [1:0] prio;
    logic act;
    logic [COUNT_W-1:0] lim;
    fixed_limits = '{1, 64, 0, 127, 4, 2};
    phase = 0;
    random_sent = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (opening_plan[i].kind == ROW_CFG)
        write_limit(opening_plan[i].limit);
      else
        send_word(opening_plan[i].act, opening_plan[i].prio, opening_plan[i].id,
                  opening_plan[i].typed, opening_plan[i].want);
    end

    while (random_sent < RANDOM_WORDS) begin
      if (phase < 6)
        lim = COUNT_W'(fixed_limits[phase]);
      else if ($urandom_range(0, 3) == 0)
        lim = COUNT_W'($urandom_range(0, 127));
      else
        lim = COUNT_W'($urandom_range(1, 8));
      write_limit(lim);
      no_idle = (phase % 4 == 2) || (phase == 1);
      // While the receiver holds off, a stream of words fills the block.
      if (phase == 1) hold_off_req = 1'b1;
      phase_words = $urandom_range(80, 140);
      while (phase_words > 0 && random_sent < RANDOM_WORDS) begin
        mode = $urandom_range(0, 99);
        main_prio = 2'($urandom_range(0, 3));
        if (mode < 45) len = $urandom_range(4, 40);
        else if (mode < 80) len = $urandom_range(4, 40);
        else len = $urandom_range(3, 16);
        if (phase == 1 && phase_words > 100) mode = 0;
        for (int k = 0; k < len && phase_words > 0 && random_sent < RANDOM_WORDS; k++) begin
          if (mode < 45) begin
            // Submit burst aimed mostly at one queue so that it can fill up.
            act = ACT_SUBMIT;
            prio = ($urandom_range(0, 3) != 0) ? main_prio : 2'($urandom_range(0, 3));
          end else if (mode < 80) begin
            act = ACT_FINISH;
            prio = 2'($urandom_range(0, 3));
          end else begin
            act = 1'($urandom_range(0, 1));
            prio = 2'($urandom_range(0, 3));
          end
          send_word(act, prio, ID_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
          phase_words--;
          random_sent++;
          if (phase == 3 && phase_words == 40) wait_drained();
        end
      end
      phase++;
    end

    // Let the last results come back, within a bound.
    in_valid <= 1'b0;
    no_idle = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("tb: %0d words sent over %0d limit settings, %0d results checked",
             words_sent, limits_written, results_seen);
    $display("tb: %0d starts, %0d queued, %0d rejected, %0d mismatches",
             starts_seen, queued_seen, rejects_seen, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
